// File: src/gccu_pkg.sv
`timescale 1ns / 1ps
package gccu_pkg;

   localparam int GCCU_ADC_W      = 8;
   localparam int GCCU_PAD_W      = 8;
   localparam int GCCU_TIME_W     = 9;
   localparam int GCCU_ROW_W      = 6;
   localparam int GCCU_LOG_W      = 9;
   localparam int GCCU_CENTER_W   = 16;
   localparam int GCCU_FRAC_BITS  = 6;

   localparam logic [GCCU_ROW_W-1:0] GCCU_INNER_ROW_LIMIT_RESET = 6'd13;
   localparam logic [GCCU_ADC_W-1:0] GCCU_ADC_MAX = 8'hFF;

   // divider geometry: numerator magnitude up to 2*354*64, divisor up to 708
   localparam int GCCU_QUOT_W  = 16;
   localparam int GCCU_DEN_W   = 10;
   localparam int GCCU_REM_W   = GCCU_DEN_W + 1;
   localparam int GCCU_ACC_W   = GCCU_REM_W + GCCU_QUOT_W;

   localparam int GCCU_QUEUE_DEPTH = 4;

   // log table construction: binary log by repeated squaring, then scale by ln 2
   localparam int GCCU_MANT_FRAC = 60;
   localparam int GCCU_LG_FRAC   = 40;
   localparam logic [63:0] GCCU_LN2_Q64 = 64'hB17217F7D1CF79AC;

   typedef logic [255:0][GCCU_LOG_W-1:0] gccu_log_rom_type;

   function automatic gccu_log_rom_type gccu_build_log_rom();
      gccu_log_rom_type rom;
      logic [63:0]      mant;
      logic [127:0]     sq;
      logic [47:0]      lg;
      logic [127:0]     prod;
      int               n;
      rom = '0;
      for (int i = 1; i < 256; i++) begin
         n = 0;
         for (int b = 0; b < 8; b++) begin
            if (((i >> b) & 1) != 0) begin
               n = b;
            end
         end
         mant = 64'(i) << (GCCU_MANT_FRAC - n);
         lg   = 48'(n) << GCCU_LG_FRAC;
         for (int k = GCCU_LG_FRAC - 1; k >= 0; k--) begin
            sq   = 128'(mant) * 128'(mant);
            mant = 64'(sq >> GCCU_MANT_FRAC);
            if (mant[GCCU_MANT_FRAC+1]) begin
               mant  = mant >> 1;
               lg[k] = 1'b1;
            end
         end
         prod   = 128'(lg) * 128'(GCCU_LN2_Q64);
         rom[i] = GCCU_LOG_W'(prod >> (GCCU_LG_FRAC + 64 - GCCU_FRAC_BITS));
      end
      return rom;
   endfunction

   // floor(64*ln(i)), entry 0 is 0
   localparam gccu_log_rom_type GCCU_LOG_ROM = gccu_build_log_rom();

   // one classified peak with its logs, as queued between front and back
   typedef struct packed {
      logic                   ok;
      logic                   inner;
      logic [GCCU_PAD_W-1:0]  pad;
      logic [GCCU_TIME_W-1:0] peak_time;
      logic [GCCU_ROW_W-1:0]  row;
      logic [GCCU_LOG_W-1:0]  la;
      logic [GCCU_LOG_W-1:0]  lb;
      logic [GCCU_LOG_W-1:0]  lc;
      logic [GCCU_LOG_W-1:0]  lp;
      logic [GCCU_LOG_W-1:0]  ltm;
      logic [GCCU_LOG_W-1:0]  ltp;
   } gccu_logs_type;

endpackage

// File: src/gccu_front.sv
`timescale 1ns / 1ps
module gccu_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [gccu_pkg::GCCU_ROW_W-1:0]  inner_row_limit,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [gccu_pkg::GCCU_PAD_W-1:0]  req_peak_pad,
   input  logic [gccu_pkg::GCCU_TIME_W-1:0] req_peak_time,
   input  logic [gccu_pkg::GCCU_ROW_W-1:0]  req_pad_row,
   input  logic [gccu_pkg::GCCU_PAD_W-1:0]  req_row_size,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]  req_adc_pad_minus2,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]  req_adc_pad_minus1,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]  req_adc_peak,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]  req_adc_pad_plus1,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]  req_adc_pad_plus2,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]  req_adc_pad_plus3,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]  req_adc_time_minus1,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]  req_adc_time_plus1,
   output logic                             out_valid,
   input  logic                             out_ready,
   output gccu_pkg::gccu_logs_type          out_data
);
   import gccu_pkg::*;

   typedef struct packed {
      logic                   ok;
      logic                   inner;
      logic [GCCU_PAD_W-1:0]  pad;
      logic [GCCU_TIME_W-1:0] peak_time;
      logic [GCCU_ROW_W-1:0]  row;
      logic [GCCU_ADC_W-1:0]  a;
      logic [GCCU_ADC_W-1:0]  b;
      logic [GCCU_ADC_W-1:0]  c;
      logic [GCCU_ADC_W-1:0]  pk;
      logic [GCCU_ADC_W-1:0]  tm;
      logic [GCCU_ADC_W-1:0]  tp;
   } sums_type;

   logic          advance;
   logic          s1_valid_ff;
   logic          s2_valid_ff;
   sums_type      s1_ff, s1_in;
   gccu_logs_type s2_ff, s2_in;

   function automatic logic [GCCU_ADC_W-1:0] sat_sum(input logic [GCCU_ADC_W-1:0] x,
                                                     input logic [GCCU_ADC_W-1:0] y);
      logic [GCCU_ADC_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[GCCU_ADC_W] ? GCCU_ADC_MAX : s[GCCU_ADC_W-1:0];
   endfunction

   // hold the whole front while its last stage waits on a full queue
   assign advance   = !s2_valid_ff || out_ready;
   assign req_ready = advance;
   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

   always_comb begin
      s1_in.ok        = req_peak_pad <= req_row_size;
      s1_in.inner     = req_pad_row < inner_row_limit;
      s1_in.pad       = req_peak_pad;
      s1_in.peak_time = req_peak_time;
      s1_in.row       = req_pad_row;
      s1_in.pk        = req_adc_peak;
      s1_in.tm        = req_adc_time_minus1;
      s1_in.tp        = req_adc_time_plus1;
      if (s1_in.inner) begin
         s1_in.a = sat_sum(req_adc_pad_minus2, req_adc_pad_minus1);
         s1_in.b = sat_sum(req_adc_peak, req_adc_pad_plus1);
         s1_in.c = sat_sum(req_adc_pad_plus2, req_adc_pad_plus3);
      end else begin
         s1_in.a = req_adc_pad_minus1;
         s1_in.b = req_adc_peak;
         s1_in.c = req_adc_pad_plus1;
      end
   end

   always_comb begin
      s2_in.ok        = s1_ff.ok;
      s2_in.inner     = s1_ff.inner;
      s2_in.pad       = s1_ff.pad;
      s2_in.peak_time = s1_ff.peak_time;
      s2_in.row       = s1_ff.row;
      s2_in.la        = GCCU_LOG_ROM[s1_ff.a];
      s2_in.lb        = GCCU_LOG_ROM[s1_ff.b];
      s2_in.lc        = GCCU_LOG_ROM[s1_ff.c];
      s2_in.lp        = GCCU_LOG_ROM[s1_ff.pk];
      s2_in.ltm       = GCCU_LOG_ROM[s1_ff.tm];
      s2_in.ltp       = GCCU_LOG_ROM[s1_ff.tp];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

endmodule

// File: src/gccu_fifo.sv
`timescale 1ns / 1ps
module gccu_fifo #(
   parameter int DEPTH = gccu_pkg::GCCU_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  gccu_pkg::gccu_logs_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output gccu_pkg::gccu_logs_type pop_data
);
   import gccu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   gccu_logs_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/gccu_back.sv
`timescale 1ns / 1ps
module gccu_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  gccu_pkg::gccu_logs_type            pop_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [gccu_pkg::GCCU_CENTER_W-1:0] rsp_center_pad,
   output logic [gccu_pkg::GCCU_CENTER_W-1:0] rsp_center_time,
   output logic [gccu_pkg::GCCU_ROW_W-1:0]    rsp_row_out,
   output logic                               rsp_peak_ok
);
   import gccu_pkg::*;

   localparam int NSTAGE = GCCU_QUOT_W;
   localparam int DIFF_W = GCCU_LOG_W + 1;
   localparam int DENS_W = GCCU_LOG_W + 2;

   typedef struct packed {
      logic [GCCU_ACC_W-1:0] acc;
      logic [GCCU_DEN_W-1:0] dmag;
      logic                  neg;
      logic                  dz;
   } lane_type;

   typedef struct packed {
      logic                   ok;
      logic [GCCU_PAD_W-1:0]  pad;
      logic [GCCU_TIME_W-1:0] peak_time;
      logic [GCCU_ROW_W-1:0]  row;
      lane_type               pad_lane;
      lane_type               time_lane;
   } div_type;

   // one restoring step: shift in a dividend bit, subtract if it fits
   function automatic lane_type lane_step(input lane_type cur);
      lane_type              nxt;
      logic [GCCU_REM_W-1:0] top;
      nxt     = cur;
      nxt.acc = cur.acc << 1;
      top     = nxt.acc[GCCU_ACC_W-1 -: GCCU_REM_W];
      if (top >= {1'b0, cur.dmag}) begin
         nxt.acc[GCCU_ACC_W-1 -: GCCU_REM_W] = top - {1'b0, cur.dmag};
         nxt.acc[0] = 1'b1;
      end
      return nxt;
   endfunction

   // set up one lane from numerator (hi - lo) and denominator 2*mid - lo - side
   function automatic lane_type lane_setup(input logic [GCCU_LOG_W-1:0] hi,
                                           input logic [GCCU_LOG_W-1:0] lo,
                                           input logic [GCCU_LOG_W-1:0] mid,
                                           input logic [GCCU_LOG_W-1:0] side,
                                           input logic                  dbl);
      lane_type              ln;
      logic [DIFF_W-1:0]     diff;
      logic [DENS_W-1:0]     den;
      logic [GCCU_LOG_W-1:0] nmag;
      logic [DENS_W-1:0]     den_neg;
      diff    = {1'b0, hi} - {1'b0, lo};
      den     = ({2'b0, mid} << 1) - {2'b0, lo} - {2'b0, side};
      nmag    = diff[DIFF_W-1] ? GCCU_LOG_W'(-diff) : diff[GCCU_LOG_W-1:0];
      den_neg = -den;
      ln.dmag = den[DENS_W-1] ? den_neg[GCCU_DEN_W-1:0] : den[GCCU_DEN_W-1:0];
      ln.neg  = diff[DIFF_W-1] ^ den[DENS_W-1];
      ln.dz   = den == '0;
      ln.acc  = GCCU_ACC_W'(nmag) << (dbl ? GCCU_FRAC_BITS + 1 : GCCU_FRAC_BITS);
      return ln;
   endfunction

   logic                                  advance;
   logic [NSTAGE:0]                       stage_valid_ff;
   div_type                               stage_ff [NSTAGE+1];
   div_type                               stage0_in;
   div_type                               last;
   logic [GCCU_QUOT_W-1:0]                q_pad, q_time;
   logic [GCCU_CENTER_W-1:0]              shift_pad, shift_time;
   logic                                  rsp_valid_ff;
   logic [GCCU_CENTER_W-1:0]              center_pad_ff, center_pad_in;
   logic [GCCU_CENTER_W-1:0]              center_time_ff, center_time_in;
   logic [GCCU_ROW_W-1:0]                 row_out_ff, row_out_in;
   logic                                  peak_ok_ff;

   // the whole back pipeline moves as one while the result register is free
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign pop_ready = advance;

   always_comb begin
      stage0_in.ok        = pop_data.ok;
      stage0_in.pad       = pop_data.pad;
      stage0_in.peak_time = pop_data.peak_time;
      stage0_in.row       = pop_data.row;
      // pad shift is s*(L(b)-L(a))*64 / den
      stage0_in.pad_lane  = lane_setup(pop_data.lb, pop_data.la, pop_data.lb, pop_data.lc,
                                       pop_data.inner);
      // time shift is (L(peak)-L(t-1))*64 / den, added afterwards
      stage0_in.time_lane = lane_setup(pop_data.lp, pop_data.ltm, pop_data.lp, pop_data.ltp,
                                       1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else if (advance) begin
         stage_valid_ff <= {stage_valid_ff[NSTAGE-1:0], pop_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff[0] <= stage0_in;
         for (int i = 1; i <= NSTAGE; i++) begin
            stage_ff[i].ok        <= stage_ff[i-1].ok;
            stage_ff[i].pad       <= stage_ff[i-1].pad;
            stage_ff[i].peak_time <= stage_ff[i-1].peak_time;
            stage_ff[i].row       <= stage_ff[i-1].row;
            stage_ff[i].pad_lane  <= lane_step(stage_ff[i-1].pad_lane);
            stage_ff[i].time_lane <= lane_step(stage_ff[i-1].time_lane);
         end
      end
   end

   always_comb begin
      last       = stage_ff[NSTAGE];
      q_pad      = last.pad_lane.acc[GCCU_QUOT_W-1:0];
      q_time     = last.time_lane.acc[GCCU_QUOT_W-1:0];
      shift_pad  = last.pad_lane.neg ? GCCU_CENTER_W'(-q_pad) : GCCU_CENTER_W'(q_pad);
      shift_time = last.time_lane.neg ? GCCU_CENTER_W'(-q_time) : GCCU_CENTER_W'(q_time);
      if (!last.ok) begin
         center_pad_in  = '0;
         center_time_in = '0;
         row_out_in     = '0;
      end else begin
         center_pad_in = GCCU_CENTER_W'({last.pad, {GCCU_FRAC_BITS{1'b0}}});
         if (!last.pad_lane.dz) begin
            center_pad_in = center_pad_in + shift_pad;
         end
         if (last.time_lane.dz) begin
            center_time_in = '0;
         end else begin
            center_time_in = GCCU_CENTER_W'({last.peak_time, {GCCU_FRAC_BITS{1'b0}}})
                             + shift_time;
         end
         row_out_in = last.row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_valid_ff[NSTAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         center_pad_ff  <= center_pad_in;
         center_time_ff <= center_time_in;
         row_out_ff     <= row_out_in;
         peak_ok_ff     <= last.ok;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_center_pad  = center_pad_ff;
   assign rsp_center_time = center_time_ff;
   assign rsp_row_out     = row_out_ff;
   assign rsp_peak_ok     = peak_ok_ff;

endmodule

// File: src/gaussian_cluster_centroid_unit.sv
`timescale 1ns / 1ps
// Gaussian cluster centroid unit. For each cluster peak it fits a Gaussian through three
// log samples in pad and in time and returns both centroids in 1/64 units (16 bits,
// wrapping). Rows below the inner_row_limit register (reset 13) use paired-pad sums
// saturated at 255 and a pad offset scale of two; other rows use single pads. A flat pad
// profile leaves the pad at the peak, a flat time profile gives time 0, and a peak pad
// beyond row_size gives an all-zero beat with peak_ok low. The unit takes one peak per
// clock while the queue has room and returns results in order. The two 16-stage signed
// dividers (one quotient bit per stage) sit behind a two-stage front (classify, log
// table) and a small queue that lets the front keep taking peaks while the result side
// is stalled.
// Write inner_row_limit only while the unit is empty.
module gaussian_cluster_centroid_unit #(
   parameter int QUEUE_DEPTH = gccu_pkg::GCCU_QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [gccu_pkg::GCCU_ROW_W-1:0]    csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [gccu_pkg::GCCU_PAD_W-1:0]    req_peak_pad,
   input  logic [gccu_pkg::GCCU_TIME_W-1:0]   req_peak_time,
   input  logic [gccu_pkg::GCCU_ROW_W-1:0]    req_pad_row,
   input  logic [gccu_pkg::GCCU_PAD_W-1:0]    req_row_size,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]    req_adc_pad_minus2,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]    req_adc_pad_minus1,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]    req_adc_peak,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]    req_adc_pad_plus1,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]    req_adc_pad_plus2,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]    req_adc_pad_plus3,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]    req_adc_time_minus1,
   input  logic [gccu_pkg::GCCU_ADC_W-1:0]    req_adc_time_plus1,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [gccu_pkg::GCCU_CENTER_W-1:0] rsp_center_pad,
   output logic [gccu_pkg::GCCU_CENTER_W-1:0] rsp_center_time,
   output logic [gccu_pkg::GCCU_ROW_W-1:0]    rsp_row_out,
   output logic                               rsp_peak_ok
);
   import gccu_pkg::*;

   // inner/outer row bound; user writes it only while drained; block does not enforce
   logic [GCCU_ROW_W-1:0] inner_row_limit_ff, inner_row_limit_in;

   // front to queue, queue to back
   logic          q_push_valid;
   logic          q_push_ready;
   gccu_logs_type q_push_data;
   logic          q_pop_valid;
   logic          q_pop_ready;
   gccu_logs_type q_pop_data;

   assign inner_row_limit_in = csr_wr_en ? csr_wr_data : inner_row_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_row_limit_ff <= GCCU_INNER_ROW_LIMIT_RESET;
      end else begin
         inner_row_limit_ff <= inner_row_limit_in;
      end
   end

   // classify the peak, saturate pair sums and look up the logs
   gccu_front u_front (
      .clock               (clock),
      .reset               (reset),
      .inner_row_limit     (inner_row_limit_ff),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_peak_pad        (req_peak_pad),
      .req_peak_time       (req_peak_time),
      .req_pad_row         (req_pad_row),
      .req_row_size        (req_row_size),
      .req_adc_pad_minus2  (req_adc_pad_minus2),
      .req_adc_pad_minus1  (req_adc_pad_minus1),
      .req_adc_peak        (req_adc_peak),
      .req_adc_pad_plus1   (req_adc_pad_plus1),
      .req_adc_pad_plus2   (req_adc_pad_plus2),
      .req_adc_pad_plus3   (req_adc_pad_plus3),
      .req_adc_time_minus1 (req_adc_time_minus1),
      .req_adc_time_plus1  (req_adc_time_plus1),
      .out_valid           (q_push_valid),
      .out_ready           (q_push_ready),
      .out_data            (q_push_data)
   );

   // decouple the front from result back-pressure
   gccu_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   // form numerators and denominators, divide, and assemble the result beat
   gccu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (q_pop_valid),
      .pop_ready       (q_pop_ready),
      .pop_data        (q_pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_center_pad  (rsp_center_pad),
      .rsp_center_time (rsp_center_time),
      .rsp_row_out     (rsp_row_out),
      .rsp_peak_ok     (rsp_peak_ok)
   );

`ifndef SYNTHESIS
   // a rejected peak must come out as an all-zero beat
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_peak_ok) |->
         (rsp_center_pad == '0 && rsp_center_time == '0 && rsp_row_out == '0))
      else $error("invalid peak beat carries non-zero fields");

   // the front only takes a peak when its last stage can drain into the queue
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!q_push_valid || q_push_ready))
      else $error("front accepted a peak while blocked by a full queue");

   // reset restores the row boundary regardless of a concurrent write
   assert property (@(posedge clock)
      $past(reset) |-> (inner_row_limit_ff == GCCU_INNER_ROW_LIMIT_RESET))
      else $error("inner row limit not restored by reset");
`endif

endmodule

// File: sim/tb_gaussian_cluster_centroid_unit.sv
`timescale 1ns / 1ps
module tb_gaussian_cluster_centroid_unit;
   import gccu_pkg::*;

   // one peak beat as offered on the req_ channel
   typedef struct {
      logic [GCCU_PAD_W-1:0]  peak_pad;
      logic [GCCU_TIME_W-1:0] peak_time;
      logic [GCCU_ROW_W-1:0]  pad_row;
      logic [GCCU_PAD_W-1:0]  row_size;
      logic [GCCU_ADC_W-1:0]  pad_m2;
      logic [GCCU_ADC_W-1:0]  pad_m1;
      logic [GCCU_ADC_W-1:0]  peak;
      logic [GCCU_ADC_W-1:0]  pad_p1;
      logic [GCCU_ADC_W-1:0]  pad_p2;
      logic [GCCU_ADC_W-1:0]  pad_p3;
      logic [GCCU_ADC_W-1:0]  time_m1;
      logic [GCCU_ADC_W-1:0]  time_p1;
   } peak_beat_type;

   // one centroid beat as seen on the rsp_ channel
   typedef struct {
      logic [GCCU_CENTER_W-1:0] center_pad;
      logic [GCCU_CENTER_W-1:0] center_time;
      logic [GCCU_ROW_W-1:0]    row_out;
      logic                     peak_ok;
   } centroid_beat_type;

   // Independent Gaussian fit: keeps its own copy of the row limit and of the
   // log table, and the centroids still owed by the unit, oldest first.
   class centroid_tracker_type;
      int                inner_row_limit;
      int                log_table[256];
      centroid_beat_type pending_centroids[$];
      int                mismatch_count;

      function new();
         inner_row_limit = int'(GCCU_INNER_ROW_LIMIT_RESET);
         mismatch_count  = 0;
         log_table[0]    = 0;
         for (int i = 1; i < 256; i++) begin
            log_table[i] = $rtoi(64.0 * $ln(real'(i)));
         end
      endfunction

      function int log64(int v);
         return log_table[(v > 255) ? 255 : v];
      endfunction

      function centroid_beat_type fit_centroid(peak_beat_type p);
         centroid_beat_type r;
         int la, lb, lc, lp, den, scale, shift;
         r.center_pad  = '0;
         r.center_time = '0;
         r.row_out     = '0;
         r.peak_ok     = 1'b0;
         if (p.peak_pad > p.row_size) begin
            return r;
         end
         if (int'(p.pad_row) < inner_row_limit) begin
            // paired pads, sums clipped at the table end
            scale = 2;
            la = log64(int'(p.pad_m2) + int'(p.pad_m1));
            lb = log64(int'(p.peak) + int'(p.pad_p1));
            lc = log64(int'(p.pad_p2) + int'(p.pad_p3));
         end else begin
            scale = 1;
            la = log64(int'(p.pad_m1));
            lb = log64(int'(p.peak));
            lc = log64(int'(p.pad_p1));
         end
         den = 2 * lb - (la + lc);
         shift = 0;
         if (den != 0) begin
            shift = (-scale * ((la - lb) * 64)) / den;
         end
         r.center_pad = GCCU_CENTER_W'(int'(p.peak_pad) * 64 + shift);
         lp  = log64(int'(p.peak));
         la  = log64(int'(p.time_m1));
         lc  = log64(int'(p.time_p1));
         den = 2 * lp - (la + lc);
         if (den != 0) begin
            shift = ((la - lp) * 64) / den;
            r.center_time = GCCU_CENTER_W'(int'(p.peak_time) * 64 - shift);
         end
         r.row_out = p.pad_row;
         r.peak_ok = 1'b1;
         return r;
      endfunction

      function void note_peak(peak_beat_type p);
         pending_centroids.push_back(fit_centroid(p));
      endfunction

      function void check_centroid(centroid_beat_type got);
         centroid_beat_type want;
         if (pending_centroids.size() == 0) begin
            $error("centroid beat with nothing outstanding: pad %0d time %0d",
                   got.center_pad, got.center_time);
            mismatch_count++;
            return;
         end
         want = pending_centroids.pop_front();
         if (got.center_pad !== want.center_pad) begin
            $error("center_pad: expected %0d, actual %0d", want.center_pad, got.center_pad);
            mismatch_count++;
         end
         if (got.center_time !== want.center_time) begin
            $error("center_time: expected %0d, actual %0d", want.center_time,
                   got.center_time);
            mismatch_count++;
         end
         if (got.row_out !== want.row_out) begin
            $error("row_out: expected %0d, actual %0d", want.row_out, got.row_out);
            mismatch_count++;
         end
         if (got.peak_ok !== want.peak_ok) begin
            $error("peak_ok: expected %0d, actual %0d", want.peak_ok, got.peak_ok);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [GCCU_ROW_W-1:0]    csr_wr_data;
   logic                     req_valid;
   logic                     req_ready;
   logic [GCCU_PAD_W-1:0]    req_peak_pad;
   logic [GCCU_TIME_W-1:0]   req_peak_time;
   logic [GCCU_ROW_W-1:0]    req_pad_row;
   logic [GCCU_PAD_W-1:0]    req_row_size;
   logic [GCCU_ADC_W-1:0]    req_adc_pad_minus2;
   logic [GCCU_ADC_W-1:0]    req_adc_pad_minus1;
   logic [GCCU_ADC_W-1:0]    req_adc_peak;
   logic [GCCU_ADC_W-1:0]    req_adc_pad_plus1;
   logic [GCCU_ADC_W-1:0]    req_adc_pad_plus2;
   logic [GCCU_ADC_W-1:0]    req_adc_pad_plus3;
   logic [GCCU_ADC_W-1:0]    req_adc_time_minus1;
   logic [GCCU_ADC_W-1:0]    req_adc_time_plus1;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [GCCU_CENTER_W-1:0] rsp_center_pad;
   logic [GCCU_CENTER_W-1:0] rsp_center_time;
   logic [GCCU_ROW_W-1:0]    rsp_row_out;
   logic                     rsp_peak_ok;

   centroid_tracker_type tracker;

   // gaps_on lets both sides idle at random; hold_rsp asks the receiver for a
   // long hold-off so that the pipeline and its queue fill up behind it
   bit gaps_on;
   bit hold_rsp;
   int row_limits[6];

   gaussian_cluster_centroid_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_peak_pad        (req_peak_pad),
      .req_peak_time       (req_peak_time),
      .req_pad_row         (req_pad_row),
      .req_row_size        (req_row_size),
      .req_adc_pad_minus2  (req_adc_pad_minus2),
      .req_adc_pad_minus1  (req_adc_pad_minus1),
      .req_adc_peak        (req_adc_peak),
      .req_adc_pad_plus1   (req_adc_pad_plus1),
      .req_adc_pad_plus2   (req_adc_pad_plus2),
      .req_adc_pad_plus3   (req_adc_pad_plus3),
      .req_adc_time_minus1 (req_adc_time_minus1),
      .req_adc_time_plus1  (req_adc_time_plus1),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_center_pad      (rsp_center_pad),
      .rsp_center_time     (rsp_center_time),
      .rsp_row_out         (rsp_row_out),
      .rsp_peak_ok         (rsp_peak_ok)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Build one peak beat from its twelve fields, in port order.
   function automatic peak_beat_type peak_of(int pad, int tim, int row, int rsz,
                                             int m2, int m1, int pk, int p1,
                                             int p2, int p3, int tm, int tp);
      peak_beat_type p;
      p.peak_pad  = GCCU_PAD_W'(pad);
      p.peak_time = GCCU_TIME_W'(tim);
      p.pad_row   = GCCU_ROW_W'(row);
      p.row_size  = GCCU_PAD_W'(rsz);
      p.pad_m2    = GCCU_ADC_W'(m2);
      p.pad_m1    = GCCU_ADC_W'(m1);
      p.peak      = GCCU_ADC_W'(pk);
      p.pad_p1    = GCCU_ADC_W'(p1);
      p.pad_p2    = GCCU_ADC_W'(p2);
      p.pad_p3    = GCCU_ADC_W'(p3);
      p.time_m1   = GCCU_ADC_W'(tm);
      p.time_p1   = GCCU_ADC_W'(tp);
      return p;
   endfunction

   // Neighbour sample no larger than the peak; now and then absent (zero).
   function automatic int flank(int pk);
      if ($urandom_range(0, 9) == 0) begin
         return 0;
      end
      return $urandom_range(0, pk);
   endfunction

   // Mostly well-formed peaks: peak pad inside the row and a falling profile
   // around the maximum. The rest is noise and peaks beyond the row end.
   function automatic peak_beat_type random_peak();
      int pad, rsz, row, pk, shape, lim;
      lim   = tracker.inner_row_limit;
      shape = $urandom_range(0, 99);
      pad   = $urandom_range(0, 255);
      if (shape < 85) begin
         rsz = ($urandom_range(0, 9) == 0) ? pad : $urandom_range(pad, 255);
      end else begin
         rsz = $urandom_range(0, 255);
      end
      if (lim > 0 && $urandom_range(0, 1) == 1) begin
         row = $urandom_range(0, lim - 1);
      end else begin
         row = $urandom_range(0, 63);
      end
      if (shape < 70) begin
         pk = $urandom_range(1, 255);
         return peak_of(pad, $urandom_range(0, 511), row, rsz,
                        flank(pk), flank(pk), pk, flank(pk), flank(pk), flank(pk),
                        flank(pk), flank(pk));
      end
      return peak_of(pad, $urandom_range(0, 511), row, rsz,
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255));
   endfunction

   // Offer one peak beat; called and left at a falling edge. Valid stays high
   // on return so that back-to-back beats need no gap.
   task automatic send_peak(input peak_beat_type p);
      while (gaps_on && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_peak_pad        <= p.peak_pad;
      req_peak_time       <= p.peak_time;
      req_pad_row         <= p.pad_row;
      req_row_size        <= p.row_size;
      req_adc_pad_minus2  <= p.pad_m2;
      req_adc_pad_minus1  <= p.pad_m1;
      req_adc_peak        <= p.peak;
      req_adc_pad_plus1   <= p.pad_p1;
      req_adc_pad_plus2   <= p.pad_p2;
      req_adc_pad_plus3   <= p.pad_p3;
      req_adc_time_minus1 <= p.time_m1;
      req_adc_time_plus1  <= p.time_p1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      tracker.note_peak(p);
      @(negedge clock);
   endtask

   // Drop valid and hold until every owed centroid has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (tracker.pending_centroids.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Write the row limit; only ever called with the unit empty.
   task automatic write_row_limit(input int lim);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= GCCU_ROW_W'(lim);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      tracker.inner_row_limit = lim;
   endtask

   // Receiver: ready changes on the falling edge. A hold-off request keeps it
   // low for a long stretch while the sender carries on.
   initial begin
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (150) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= !(gaps_on && $urandom_range(0, 99) < 30);
         end
      end
   end

   // Sample the result beat at the rising edge at which it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         centroid_beat_type got;
         got.center_pad  = rsp_center_pad;
         got.center_time = rsp_center_time;
         got.row_out     = rsp_row_out;
         got.peak_ok     = rsp_peak_ok;
         tracker.check_centroid(got);
      end
   end

   // Stimulus: directed corners at the reset row limit, then random phases
   // across several limits with the unit drained before each write.
   initial begin
      tracker             = new();
      gaps_on             = 1'b1;
      hold_rsp            = 1'b0;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_valid           = 1'b0;
      req_peak_pad        = '0;
      req_peak_time       = '0;
      req_pad_row         = '0;
      req_row_size        = '0;
      req_adc_pad_minus2  = '0;
      req_adc_pad_minus1  = '0;
      req_adc_peak        = '0;
      req_adc_pad_plus1   = '0;
      req_adc_pad_plus2   = '0;
      req_adc_pad_plus3   = '0;
      req_adc_time_minus1 = '0;
      req_adc_time_plus1  = '0;
      rsp_ready           = 1'b0;
      row_limits          = '{0, 63, 13, 1, 62, 0};
      row_limits[3]       = $urandom_range(1, 62);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // all zero: flat in both directions, so pad at peak and time 0
      send_peak(peak_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // all at full scale, outer row
      send_peak(peak_of(255, 511, 63, 255, 255, 255, 255, 255, 255, 255, 255, 255));
      // peak pad beyond the row end: all-zero beat
      send_peak(peak_of(10, 100, 5, 9, 20, 60, 200, 80, 30, 10, 50, 40));
      send_peak(peak_of(255, 511, 63, 254, 255, 255, 255, 255, 255, 255, 255, 255));
      // peak pad on the row end is still valid
      send_peak(peak_of(77, 1, 63, 77, 1, 2, 3, 4, 5, 6, 7, 8));
      // inner row with every pair sum over 255 (clipped before lookup)
      send_peak(peak_of(100, 300, 0, 200, 200, 200, 255, 255, 200, 200, 120, 130));
      // last inner row and first outer row at the reset limit
      send_peak(peak_of(40, 200, 12, 100, 10, 50, 180, 90, 30, 5, 70, 60));
      send_peak(peak_of(40, 200, 13, 100, 10, 50, 180, 90, 30, 5, 70, 60));
      send_peak(peak_of(120, 50, 40, 150, 0, 60, 220, 140, 0, 0, 90, 110));
      // absent neighbours on the left, then on the right
      send_peak(peak_of(0, 10, 20, 127, 0, 0, 150, 60, 20, 0, 0, 80));
      send_peak(peak_of(127, 400, 3, 127, 40, 90, 160, 0, 0, 0, 100, 0));
      // pad shift below zero at pad 0, time shift upward from time 0
      send_peak(peak_of(0, 0, 30, 255, 0, 255, 100, 1, 0, 0, 200, 50));
      // peak lower than its neighbours: negative denominators
      send_peak(peak_of(200, 256, 50, 255, 0, 200, 10, 200, 0, 0, 180, 190));
      send_peak(peak_of(3, 2, 1, 50, 250, 250, 5, 5, 250, 250, 200, 220));
      // flat non-zero profile in an outer row
      send_peak(peak_of(33, 33, 33, 200, 90, 90, 90, 90, 90, 90, 90, 90));
      // alternating bit patterns on every field
      send_peak(peak_of(170, 341, 42, 170, 85, 170, 85, 170, 85, 170, 85, 170));
      send_peak(peak_of(85, 170, 21, 85, 170, 85, 170, 85, 170, 85, 170, 85));
      drain_results();

      for (int ph = 0; ph < 6; ph++) begin
         write_row_limit(row_limits[ph]);
         // phase 2 runs flat out on both sides
         gaps_on = (ph != 2);
         for (int n = 0; n < 330; n++) begin
            if (ph == 1 && n == 40) begin
               hold_rsp = 1'b1;
            end
            if (ph == 3 && n == 165) begin
               drain_results();
            end
            send_peak(random_peak());
         end
         drain_results();
      end

      // let any stray beat show up before the verdict
      repeat (40) @(posedge clock);
      if (tracker.mismatch_count == 0) begin
         $display("[gaussian_cluster_centroid_unit] OK");
      end else begin
         $display("[gaussian_cluster_centroid_unit] ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("[gaussian_cluster_centroid_unit] ERROR");
      $finish;
   end

endmodule
